/* design/quad_x_mixer_pwm_duty_assert.svh */
// Assertion macros shared by the mixer modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef QUAD_X_MIXER_PWM_DUTY_ASSERT_SVH
`define QUAD_X_MIXER_PWM_DUTY_ASSERT_SVH
`ifndef SYNTHESIS
`define QXM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qxm assertion failed");
`define QXM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qxm assertion failed");
`else
`define QXM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define QXM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/qxm_pkg.sv */
// Package for the X-frame motor mixer: field widths, codes and reset values.
// Depends on nothing; used by the channel interfaces, the divider and the top level.
package qxm_pkg;

   localparam int DUTY_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF = 12;

   localparam int FUNC_W     = 2;
   localparam int THR_W      = 13;
   localparam int AXIS_W     = 14;
   localparam int US_W       = 15;
   localparam int DUTY_W     = 16;
   localparam int MASK_W     = 4;
   localparam int MOTORS     = 4;
   localparam int MIX_W      = 17;
   localparam int DIV_DEN_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [US_W-1:0] MAX_US = '1;

   localparam logic [THR_W-1:0] THROTTLE_MIN_RST  = 13'd0;
   localparam logic [THR_W-1:0] THROTTLE_MAX_RST  = 13'd4096;
   localparam logic [THR_W-1:0] IDLE_THROTTLE_RST = 13'd205;
   localparam logic [US_W-1:0]  PULSE_MIN_RST     = 15'd1000;
   localparam logic [US_W-1:0]  PULSE_MAX_RST     = 15'd2000;
   localparam logic [US_W-1:0]  PULSE_OFF_RST     = 15'd1000;
   localparam logic [US_W-1:0]  PERIOD_RST        = 15'd2500;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_MIX = 2'd0,
      FUNC_OFF = 2'd1,
      FUNC_ARM = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THROTTLE_MIN  = 3'd0,
      CSR_THROTTLE_MAX  = 3'd1,
      CSR_IDLE_THROTTLE = 3'd2,
      CSR_PULSE_MIN     = 3'd3,
      CSR_PULSE_MAX     = 3'd4,
      CSR_PULSE_OFF     = 3'd5,
      CSR_PERIOD        = 3'd6
   } csr_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* design/qxm_if.sv */
// Valid/ready channel interfaces for mixer commands and motor duty results.
// Depends on qxm_pkg for the field widths.
interface qxm_req_if;
   import qxm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [THR_W-1:0]         throttle_cmd;
   logic signed [AXIS_W-1:0] roll_cmd;
   logic signed [AXIS_W-1:0] pitch_cmd;
   logic signed [AXIS_W-1:0] yaw_cmd;

   modport source (output valid, func, throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd,
                   input ready);
   modport sink (input valid, func, throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd,
                 output ready);
endinterface

interface qxm_rsp_if;
   import qxm_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_front_left;
   logic [DUTY_W-1:0] duty_front_right;
   logic [DUTY_W-1:0] duty_rear_left;
   logic [DUTY_W-1:0] duty_rear_right;
   logic [MASK_W-1:0] write_mask;
   logic              armed_flag;

   modport source (output valid, duty_front_left, duty_front_right, duty_rear_left,
                   duty_rear_right, write_mask, armed_flag, input ready);
   modport sink (input valid, duty_front_left, duty_front_right, duty_rear_left,
                 duty_rear_right, write_mask, armed_flag, output ready);
endinterface

/* design/quad_x_mixer_pwm_duty.sv */
// X-frame quadcopter motor mixer: one transaction carries a mix, off or arm command and
// returns four PWM duty counts, a write mask and the armed status. All divisions go
// through one shared bit-serial divider that yields max(DUTY_BITS, 15) quotient bits per
// division. Every transaction runs four duty divisions, and a desaturated mix first runs
// four scaling divisions. A new command is accepted while a finished result waits.
`include "quad_x_mixer_pwm_duty_assert.svh"

module quad_x_mixer_pwm_duty #(
   parameter int DUTY_BITS = qxm_pkg::DUTY_BITS_DEF,
   parameter int FRAC_BITS = qxm_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   qxm_req_if.sink                          req_chan,
   qxm_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [qxm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qxm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import qxm_pkg::*;

   localparam int QUO_W   = max_int(DUTY_BITS, US_W);
   localparam int NUM_W   = QUO_W + DIV_DEN_W;
   localparam int AXC_W   = AXIS_W + 1;
   localparam int AW      = max_int(AXC_W, FRAC_BITS + 2);
   localparam int CW      = max_int(THR_W, FRAC_BITS + 1);
   localparam int PROD_W  = THR_W + 1 + US_W + 1;
   localparam int DPROD_W = US_W + DUTY_BITS;
   localparam int SPROD_W = DIV_DEN_W + THR_W;

   localparam logic signed [AW-1:0] ONE_S     = AW'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0] NEG_ONE_S = -ONE_S;
   localparam logic [CW-1:0]        ONE_C     = CW'(1) << FRAC_BITS;
   localparam logic [DUTY_BITS-1:0] MAXD      = '1;
   localparam logic [1:0]           LAST_MOTOR = 2'(MOTORS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MIX,
      S_PEAK,
      S_SCALE_MUL,
      S_SCALE_DIV,
      S_LIMIT,
      S_PULSE_MUL,
      S_PULSE_WR,
      S_DUTY_MUL,
      S_DUTY_DIV,
      S_DONE
   } state_type;

   // Configuration registers.
   logic [THR_W-1:0] tmin_ff, tmax_ff, idle_thr_ff;
   logic [US_W-1:0]  pmin_ff, pmax_ff, poff_ff, period_ff;

   // Sequencer state and working registers.
   state_type                state_ff;
   logic [FUNC_W-1:0]        func_ff;
   logic [THR_W-1:0]         thr_raw_ff;
   logic signed [AXIS_W-1:0] roll_raw_ff, pitch_raw_ff, yaw_raw_ff;
   logic [THR_W-1:0]         thr_ff;
   logic signed [AXC_W-1:0]  roll_ff, pitch_ff, yaw_ff;
   logic signed [MIX_W-1:0]  m4_ff [MOTORS];
   logic [THR_W-1:0]         idle_ff;
   logic [DIV_DEN_W-1:0]     hi_ff;
   logic                     scale_ff;
   logic [1:0]               motor_ff;
   logic [THR_W-1:0]         m_ff;
   logic signed [PROD_W-1:0] pprod_ff;
   logic [DUTY_W-1:0]        duty_ff [MOTORS];
   logic [MASK_W-1:0]        mask_ff;
   logic                     armed_ff;
   logic [US_W-1:0]          last_ff [MOTORS];

   logic                     rsp_valid_ff;
   logic [DUTY_W-1:0]        rsp_duty_ff [MOTORS];
   logic [MASK_W-1:0]        rsp_mask_ff;
   logic                     rsp_armed_ff;

   // Combinational datapath.
   logic [THR_W-1:0]         thr_clamp;
   logic signed [AXC_W-1:0]  roll_clamp, pitch_clamp, yaw_clamp;
   logic signed [MIX_W-1:0]  t4, r4, p4, y4;
   logic signed [MIX_W-1:0]  m4_in [MOTORS];
   logic [THR_W-1:0]         idle_in;
   logic signed [MIX_W-1:0]  hi_a, hi_b, hi_all, tmax4;
   logic                     scale_hit;
   logic signed [MIX_W-1:0]  sel_m4, mag;
   logic                     neg;
   logic [DIV_DEN_W-1:0]     mag16, raw_mag;
   logic [SPROD_W-1:0]       scale_prod;
   logic signed [MIX_W-1:0]  m_raw, lo_idle, lo_min, hi_lim, clamp1, clamp2;
   logic [THR_W-1:0]         t_p;
   logic signed [US_W:0]     d_s;
   logic signed [PROD_W-1:0] pprod_in, sh, us_s, us_max_s;
   logic [US_W-1:0]          us_sat;
   logic [US_W-1:0]          per1, duty_u;
   logic [DPROD_W-1:0]       duty_prod;
   logic                     div_start, div_done;
   logic [NUM_W-1:0]         div_numer;
   logic [DIV_DEN_W-1:0]     div_denom;
   logic [QUO_W-1:0]         div_quo;

   function automatic logic signed [AXC_W-1:0] clamp_axis(input logic signed [AXIS_W-1:0] v);
      logic signed [AW-1:0] vx;
      vx = AW'(v);
      if (vx < NEG_ONE_S) begin
         return AXC_W'(NEG_ONE_S);
      end else if (vx > ONE_S) begin
         return AXC_W'(ONE_S);
      end
      return AXC_W'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         tmin_ff     <= THROTTLE_MIN_RST;
         tmax_ff     <= THROTTLE_MAX_RST;
         idle_thr_ff <= IDLE_THROTTLE_RST;
         pmin_ff     <= PULSE_MIN_RST;
         pmax_ff     <= PULSE_MAX_RST;
         poff_ff     <= PULSE_OFF_RST;
         period_ff   <= PERIOD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THROTTLE_MIN:  tmin_ff     <= csr_wdata[THR_W-1:0];
            CSR_THROTTLE_MAX:  tmax_ff     <= csr_wdata[THR_W-1:0];
            CSR_IDLE_THROTTLE: idle_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_PULSE_MIN:     pmin_ff     <= csr_wdata[US_W-1:0];
            CSR_PULSE_MAX:     pmax_ff     <= csr_wdata[US_W-1:0];
            CSR_PULSE_OFF:     poff_ff     <= csr_wdata[US_W-1:0];
            CSR_PERIOD:        period_ff   <= csr_wdata[US_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      thr_clamp   = (thr_raw_ff > tmax_ff) ? tmax_ff : thr_raw_ff;
      roll_clamp  = clamp_axis(roll_raw_ff);
      pitch_clamp = clamp_axis(pitch_raw_ff);
      yaw_clamp   = clamp_axis(yaw_raw_ff);

      t4 = $signed({2'b00, thr_ff, 2'b00});
      r4 = MIX_W'(roll_ff);
      p4 = MIX_W'(pitch_ff);
      y4 = MIX_W'(yaw_ff);
      m4_in[0] = t4 + p4 + r4 - y4;
      m4_in[1] = t4 - p4 - r4 - y4;
      m4_in[2] = t4 - p4 + r4 + y4;
      m4_in[3] = t4 + p4 - r4 + y4;
      idle_in  = (thr_ff > idle_thr_ff) ? idle_thr_ff : '0;

      hi_a      = (m4_ff[1] > m4_ff[0]) ? m4_ff[1] : m4_ff[0];
      hi_b      = (m4_ff[3] > m4_ff[2]) ? m4_ff[3] : m4_ff[2];
      hi_all    = (hi_b > hi_a) ? hi_b : hi_a;
      tmax4     = $signed({2'b00, tmax_ff, 2'b00});
      scale_hit = (hi_all > tmax4);

      sel_m4     = m4_ff[motor_ff];
      neg        = sel_m4[MIX_W-1];
      mag        = neg ? -sel_m4 : sel_m4;
      mag16      = mag[DIV_DEN_W-1:0];
      scale_prod = mag16 * tmax_ff;

      // Both the scaled and the quarter path truncate toward zero on the magnitude.
      raw_mag = scale_ff ? DIV_DEN_W'(div_quo) : (mag16 >> 2);
      m_raw   = neg ? -$signed({1'b0, raw_mag}) : $signed({1'b0, raw_mag});
      lo_idle = $signed({4'b0000, idle_ff});
      lo_min  = $signed({4'b0000, tmin_ff});
      hi_lim  = $signed({4'b0000, tmax_ff});
      clamp1  = (m_raw < lo_idle) ? lo_idle : ((m_raw > hi_lim) ? hi_lim : m_raw);
      clamp2  = (clamp1 < lo_min) ? lo_min : ((clamp1 > hi_lim) ? hi_lim : clamp1);

      t_p      = (CW'(m_ff) > ONE_C) ? THR_W'(ONE_C) : m_ff;
      d_s      = $signed({1'b0, pmax_ff}) - $signed({1'b0, pmin_ff});
      pprod_in = $signed({1'b0, t_p}) * d_s;

      sh       = pprod_ff >>> FRAC_BITS;
      us_s     = sh + $signed({{(PROD_W-US_W){1'b0}}, pmin_ff});
      us_max_s = $signed({{(PROD_W-US_W){1'b0}}, MAX_US});
      if (us_s < 0) begin
         us_sat = '0;
      end else if (us_s > us_max_s) begin
         us_sat = MAX_US;
      end else begin
         us_sat = us_s[US_W-1:0];
      end

      per1      = (period_ff == '0) ? US_W'(1) : period_ff;
      duty_u    = (last_ff[motor_ff] > per1) ? per1 : last_ff[motor_ff];
      duty_prod = duty_u * MAXD;

      div_start = (state_ff == S_SCALE_MUL) || (state_ff == S_DUTY_MUL);
      div_numer = (state_ff == S_SCALE_MUL) ? NUM_W'(scale_prod) : NUM_W'(duty_prod);
      div_denom = (state_ff == S_SCALE_MUL) ? hi_ff : DIV_DEN_W'(per1);
   end

   qxm_serial_div #(
      .QUO_W (QUO_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         armed_ff     <= 1'b0;
         for (int i = 0; i < MOTORS; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         if (rsp_chan.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  func_ff      <= req_chan.func;
                  thr_raw_ff   <= req_chan.throttle_cmd;
                  roll_raw_ff  <= req_chan.roll_cmd;
                  pitch_raw_ff <= req_chan.pitch_cmd;
                  yaw_raw_ff   <= req_chan.yaw_cmd;
                  mask_ff      <= '0;
                  motor_ff     <= '0;
                  state_ff     <= S_DECODE;
               end
            end
            S_DECODE: begin
               unique case (func_ff)
                  FUNC_MIX: begin
                     if (armed_ff) begin
                        thr_ff   <= thr_clamp;
                        roll_ff  <= roll_clamp;
                        pitch_ff <= pitch_clamp;
                        yaw_ff   <= yaw_clamp;
                        state_ff <= S_MIX;
                     end else begin
                        state_ff <= S_DUTY_MUL;
                     end
                  end
                  FUNC_OFF: begin
                     for (int i = 0; i < MOTORS; i++) begin
                        if (last_ff[i] != poff_ff) begin
                           last_ff[i] <= poff_ff;
                           mask_ff[i] <= 1'b1;
                        end
                     end
                     armed_ff <= 1'b0;
                     state_ff <= S_DUTY_MUL;
                  end
                  FUNC_ARM: begin
                     for (int i = 0; i < MOTORS; i++) begin
                        last_ff[i] <= pmin_ff;
                     end
                     mask_ff  <= '1;
                     armed_ff <= 1'b1;
                     state_ff <= S_DUTY_MUL;
                  end
                  default: state_ff <= S_DUTY_MUL;
               endcase
            end
            S_MIX: begin
               for (int i = 0; i < MOTORS; i++) begin
                  m4_ff[i] <= m4_in[i];
               end
               idle_ff  <= idle_in;
               state_ff <= S_PEAK;
            end
            S_PEAK: begin
               scale_ff <= scale_hit;
               hi_ff    <= hi_all[DIV_DEN_W-1:0];
               state_ff <= scale_hit ? S_SCALE_MUL : S_LIMIT;
            end
            S_SCALE_MUL: begin
               state_ff <= S_SCALE_DIV;
            end
            S_SCALE_DIV: begin
               if (div_done) begin
                  state_ff <= S_LIMIT;
               end
            end
            S_LIMIT: begin
               m_ff     <= clamp2[THR_W-1:0];
               state_ff <= S_PULSE_MUL;
            end
            S_PULSE_MUL: begin
               pprod_ff <= pprod_in;
               state_ff <= S_PULSE_WR;
            end
            S_PULSE_WR: begin
               if (us_sat != last_ff[motor_ff]) begin
                  last_ff[motor_ff] <= us_sat;
                  mask_ff[motor_ff] <= 1'b1;
               end
               motor_ff <= motor_ff + 1'b1;
               if (motor_ff == LAST_MOTOR) begin
                  state_ff <= S_DUTY_MUL;
               end else begin
                  state_ff <= scale_ff ? S_SCALE_MUL : S_LIMIT;
               end
            end
            S_DUTY_MUL: begin
               state_ff <= S_DUTY_DIV;
            end
            S_DUTY_DIV: begin
               if (div_done) begin
                  duty_ff[motor_ff] <= DUTY_W'(div_quo);
                  motor_ff          <= motor_ff + 1'b1;
                  state_ff          <= (motor_ff == LAST_MOTOR) ? S_DONE : S_DUTY_MUL;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_duty_ff  <= duty_ff;
                  rsp_mask_ff  <= mask_ff;
                  rsp_armed_ff <= armed_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready             = (state_ff == S_IDLE);
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.duty_front_left   = rsp_duty_ff[0];
   assign rsp_chan.duty_front_right  = rsp_duty_ff[1];
   assign rsp_chan.duty_rear_left    = rsp_duty_ff[2];
   assign rsp_chan.duty_rear_right   = rsp_duty_ff[3];
   assign rsp_chan.write_mask        = rsp_mask_ff;
   assign rsp_chan.armed_flag        = rsp_armed_ff;

   `QXM_ASSERT_NXT(a_one_transaction, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `QXM_ASSERT_IMP(a_div_done_expected, clock, reset, div_done, (state_ff == S_SCALE_DIV) || (state_ff == S_DUTY_DIV))
   `QXM_ASSERT_IMP(a_arm_forces_all, clock, reset, (state_ff == S_DONE) && (func_ff == FUNC_ARM), (mask_ff == '1) && armed_ff)
   `QXM_ASSERT_IMP(a_disarmed_mix_quiet, clock, reset, (state_ff == S_DONE) && (func_ff == FUNC_MIX) && !armed_ff, mask_ff == '0)

endmodule

/* design/qxm_serial_div.sv */
// Restoring divider that produces one quotient bit per clock cycle.
// Depends on qxm_pkg for default widths and on the shared assertion macros.
`include "quad_x_mixer_pwm_duty_assert.svh"

module qxm_serial_div #(
   parameter int QUO_W = qxm_pkg::DUTY_BITS_DEF,
   parameter int DEN_W = qxm_pkg::DIV_DEN_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [QUO_W+DEN_W-1:0] numer,
   input  logic [DEN_W-1:0]       denom,
   output logic                   done,
   output logic [QUO_W-1:0]       quotient
);
   localparam int NUM_W = QUO_W + DEN_W;
   localparam int CNT_W = $clog2(QUO_W);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [QUO_W-1:0] work_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;
   logic [DEN_W-1:0] rem_in;
   logic [QUO_W-1:0] work_in;

   // The caller guarantees that the quotient fits in QUO_W bits, so the upper
   // part of the dividend is already smaller than the divisor.
   always_comb begin
      trial   = {rem_ff, work_ff[QUO_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_in = {work_ff[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= numer[NUM_W-1:QUO_W];
         work_ff <= numer[QUO_W-1:0];
         den_ff  <= denom;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

   `QXM_ASSERT_IMP(a_div_no_restart, clock, reset, start, !busy_ff)
   `QXM_ASSERT_NXT(a_div_finish, clock, reset, busy_ff && (cnt_ff == '0), done_ff && !busy_ff)
   `QXM_ASSERT_IMP(a_div_started, clock, reset, $rose(busy_ff), $past(start))

endmodule

/* dv/quad_x_mixer_pwm_duty_test.sv */
// Self-checking testbench for the X-frame motor mixer: directed and random commands
// under several register settings, checked by a scoreboard that predicts every duty.
// Depends on qxm_pkg, the qxm_req_if/qxm_rsp_if channels and quad_x_mixer_pwm_duty.
module quad_x_mixer_pwm_duty_test;
   import qxm_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam longint ONE         = longint'(1) << FRAC_BITS_DEF;
   localparam longint DUTY_FULL   = (longint'(1) << DUTY_BITS_DEF) - 1;
   localparam int     HOLD_CYCLES = 600;
   localparam int     SETTLE      = 4;
   localparam int     TAIL_CYCLES = 320;
   localparam int     LIMIT       = 1000000;
   localparam int     PHASE_ITEMS = 104;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [THR_W-1:0]         throttle;
      logic signed [AXIS_W-1:0] roll;
      logic signed [AXIS_W-1:0] pitch;
      logic signed [AXIS_W-1:0] yaw;
   } mix_cmd_t;

   typedef struct packed {
      logic [MOTORS-1:0][DUTY_W-1:0] duty;
      logic [MASK_W-1:0]             mask;
      logic                          armed;
   } duty_result_t;

   class motor_duty_board;
      logic [THR_W-1:0] thr_min, thr_max, idle_thr;
      logic [US_W-1:0]  pulse_min, pulse_max, pulse_off, period;
      logic [US_W-1:0]  stored_pulse[MOTORS];
      bit               armed;
      duty_result_t     pending_duties[$];
      int mismatches, results_seen, armed_mixes, desat_mixes, offs, arms, ignored;

      function new();
         thr_min   = THROTTLE_MIN_RST;
         thr_max   = THROTTLE_MAX_RST;
         idle_thr  = IDLE_THROTTLE_RST;
         pulse_min = PULSE_MIN_RST;
         pulse_max = PULSE_MAX_RST;
         pulse_off = PULSE_OFF_RST;
         period    = PERIOD_RST;
         foreach (stored_pulse[i]) stored_pulse[i] = '0;
         armed = 1'b0;
      endfunction

      function void write_reg(csr_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_THROTTLE_MIN:  thr_min   = value[THR_W-1:0];
            CSR_THROTTLE_MAX:  thr_max   = value[THR_W-1:0];
            CSR_IDLE_THROTTLE: idle_thr  = value[THR_W-1:0];
            CSR_PULSE_MIN:     pulse_min = value[US_W-1:0];
            CSR_PULSE_MAX:     pulse_max = value[US_W-1:0];
            CSR_PULSE_OFF:     pulse_off = value[US_W-1:0];
            CSR_PERIOD:        period    = value[US_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function logic [US_W-1:0] pulse_of(longint t);
         longint tc, span, num, q;
         tc   = clamp(t, 0, ONE);
         span = longint'(pulse_max) - longint'(pulse_min);
         num  = longint'(pulse_min) * ONE + tc * span;
         q    = num / ONE;
         if ((num % ONE) != 0 && num < 0) q = q - 1;
         q = clamp(q, 0, 32767);
         return q[US_W-1:0];
      endfunction

      function logic [DUTY_W-1:0] duty_of(logic [US_W-1:0] us);
         longint per, u, d;
         per = (period == 0) ? 1 : longint'(period);
         u   = (longint'(us) > per) ? per : longint'(us);
         d   = (u * DUTY_FULL) / per;
         return d[DUTY_W-1:0];
      endfunction

      function void note_command(mix_cmd_t cmd);
         logic [MASK_W-1:0] mask;
         logic [US_W-1:0]   us;
         longint t, r, p, y, tmax, hi4, idle, m;
         longint m4[MOTORS];
         duty_result_t want;
         mask = '0;
         if (cmd.func == FUNC_MIX && armed) begin
            armed_mixes++;
            tmax  = longint'(thr_max);
            t     = clamp(longint'(cmd.throttle), 0, tmax);
            r     = clamp(longint'(cmd.roll), -ONE, ONE);
            p     = clamp(longint'(cmd.pitch), -ONE, ONE);
            y     = clamp(longint'(cmd.yaw), -ONE, ONE);
            m4[0] = 4 * t + p + r - y;
            m4[1] = 4 * t - p - r - y;
            m4[2] = 4 * t - p + r + y;
            m4[3] = 4 * t + p - r + y;
            hi4 = m4[0];
            for (int i = 1; i < MOTORS; i++) if (m4[i] > hi4) hi4 = m4[i];
            idle = (t > longint'(idle_thr)) ? longint'(idle_thr) : 0;
            if (hi4 > 4 * tmax) desat_mixes++;
            for (int i = 0; i < MOTORS; i++) begin
               if (hi4 > 4 * tmax) m = (m4[i] * tmax) / hi4;
               else m = m4[i] / 4;
               m  = clamp(m, idle, tmax);
               m  = clamp(m, longint'(thr_min), tmax);
               us = pulse_of(m);
               if (us != stored_pulse[i]) begin
                  stored_pulse[i] = us;
                  mask[i] = 1'b1;
               end
            end
         end else if (cmd.func == FUNC_OFF) begin
            offs++;
            for (int i = 0; i < MOTORS; i++) begin
               if (pulse_off != stored_pulse[i]) begin
                  stored_pulse[i] = pulse_off;
                  mask[i] = 1'b1;
               end
            end
            armed = 1'b0;
         end else if (cmd.func == FUNC_ARM) begin
            arms++;
            for (int i = 0; i < MOTORS; i++) stored_pulse[i] = pulse_min;
            mask  = '1;
            armed = 1'b1;
         end else begin
            ignored++;
         end
         for (int i = 0; i < MOTORS; i++) want.duty[i] = duty_of(stored_pulse[i]);
         want.mask  = mask;
         want.armed = armed;
         pending_duties.push_back(want);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch at result %0d: %s is %0d, expected %0d",
                  results_seen, what, got, want);
         mismatches++;
      endtask

      task check_duties(duty_result_t got);
         duty_result_t want;
         results_seen++;
         if (pending_duties.size() == 0) begin
            report_mismatch("unrequested result, write mask", got.mask, 0);
            return;
         end
         want = pending_duties.pop_front();
         for (int i = 0; i < MOTORS; i++) begin
            if (got.duty[i] !== want.duty[i])
               report_mismatch($sformatf("duty of motor %0d", i), got.duty[i], want.duty[i]);
         end
         if (got.mask !== want.mask) report_mismatch("write mask", got.mask, want.mask);
         if (got.armed !== want.armed) report_mismatch("armed flag", got.armed, want.armed);
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   qxm_req_if req_chan ();
   qxm_rsp_if rsp_chan ();

   quad_x_mixer_pwm_duty DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   motor_duty_board board = new();
   mix_cmd_t last_cmd;
   bit       hold_results;
   int       sent_count;
   int       settings_applied;
   int       cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      mix_cmd_t     seen_cmd;
      duty_result_t seen_duty;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen_cmd.func     = req_chan.func;
            seen_cmd.throttle = req_chan.throttle_cmd;
            seen_cmd.roll     = req_chan.roll_cmd;
            seen_cmd.pitch    = req_chan.pitch_cmd;
            seen_cmd.yaw      = req_chan.yaw_cmd;
            board.note_command(seen_cmd);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_duty.duty[0] = rsp_chan.duty_front_left;
            seen_duty.duty[1] = rsp_chan.duty_front_right;
            seen_duty.duty[2] = rsp_chan.duty_rear_left;
            seen_duty.duty[3] = rsp_chan.duty_rear_right;
            seen_duty.mask    = rsp_chan.write_mask;
            seen_duty.armed   = rsp_chan.armed_flag;
            board.check_duties(seen_duty);
         end
      end
   end

   // Ready is always high, random, in a sparse pattern, or held low on request.
   initial begin
      int style, style_left;
      style_left = 0;
      style      = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (style_left == 0) begin
            style      = $urandom_range(0, 2);
            style_left = $urandom_range(50, 300);
         end
         style_left--;
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            case (style)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 99) >= 35);
               default: rsp_chan.ready <= ((style_left % 7) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) @(posedge clock) cycle_count++;
      $display("Verification failed");
      $finish;
   end

   function automatic mix_cmd_t make_command(logic [FUNC_W-1:0] f, int thr, int r, int p,
                                             int y);
      mix_cmd_t cmd;
      cmd.func     = f;
      cmd.throttle = THR_W'(thr);
      cmd.roll     = AXIS_W'(r);
      cmd.pitch    = AXIS_W'(p);
      cmd.yaw      = AXIS_W'(y);
      return cmd;
   endfunction

   function automatic int random_axis();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return -8192;
         1:       return 8191;
         2:       return int'($urandom_range(0, 16383)) - 8192;
         3:       return $urandom_range(0, 1) ? 4096 + int'($urandom_range(0, 1))
                                              : -4096 - int'($urandom_range(0, 1));
         default: return int'($urandom_range(0, 3000)) - 1500;
      endcase
   endfunction

   task automatic send_command(input mix_cmd_t cmd);
      req_chan.valid        <= 1'b1;
      req_chan.func         <= cmd.func;
      req_chan.throttle_cmd <= cmd.throttle;
      req_chan.roll_cmd     <= cmd.roll;
      req_chan.pitch_cmd    <= cmd.pitch;
      req_chan.yaw_cmd      <= cmd.yaw;
      do @(posedge clock); while (!req_chan.ready);
      last_cmd = cmd;
      sent_count++;
   endtask

   task automatic pause_sender(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      while (board.results_seen < sent_count) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, CSR_DATA_W'(value));
      @(posedge clock);
   endtask

   task automatic apply_setting(input int tmin, input int tmax, input int idle,
                                input int pmin, input int pmax, input int poff,
                                input int per);
      wait_results_drained();
      write_csr(CSR_THROTTLE_MIN, tmin);
      write_csr(CSR_THROTTLE_MAX, tmax);
      write_csr(CSR_IDLE_THROTTLE, idle);
      write_csr(CSR_PULSE_MIN, pmin);
      write_csr(CSR_PULSE_MAX, pmax);
      write_csr(CSR_PULSE_OFF, poff);
      write_csr(CSR_PERIOD, per);
      settings_applied++;
   endtask

   // Mostly armed mixes; arming is favored while disarmed so that mixes reach the mixer.
   task automatic run_random(input int count, input bit gapless);
      int done, burst, p, sel, thr;
      logic [FUNC_W-1:0] f;
      mix_cmd_t cmd;
      done  = 0;
      burst = 0;
      while (done < count) begin
         if ($urandom_range(0, 99) < 12) begin
            cmd = last_cmd;
         end else begin
            p = $urandom_range(0, 99);
            if (!board.armed && $urandom_range(0, 1)) f = FUNC_ARM;
            else if (p < 4) f = FUNC_UNUSED;
            else if (p < 11) f = FUNC_OFF;
            else if (p < 16) f = FUNC_ARM;
            else f = FUNC_MIX;
            sel = $urandom_range(0, 9);
            case (sel)
               0:       thr = 0;
               1:       thr = 8191;
               2:       thr = $urandom_range(0, 8191);
               3:       thr = board.thr_max;
               4:       thr = board.idle_thr + $urandom_range(0, 1);
               default: thr = $urandom_range(0, board.thr_max);
            endcase
            cmd = make_command(f, thr, random_axis(), random_axis(), random_axis());
         end
         if (!gapless) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 16);
               p = $urandom_range(0, 99);
               if (p < 60) pause_sender($urandom_range(1, 5));
               else if (p < 90) pause_sender($urandom_range(6, 40));
               else pause_sender($urandom_range(41, 120));
            end
            burst--;
         end
         send_command(cmd);
         done++;
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_THROTTLE_MIN;
      csr_wdata             <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.func         <= FUNC_MIX;
      req_chan.throttle_cmd <= '0;
      req_chan.roll_cmd     <= '0;
      req_chan.pitch_cmd    <= '0;
      req_chan.yaw_cmd      <= '0;
      last_cmd     = make_command(FUNC_MIX, 0, 0, 0, 0);
      hold_results = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(make_command(FUNC_MIX, 2000, 100, -100, 50));
      send_command(make_command(FUNC_UNUSED, 8191, 8191, 8191, 8191));
      send_command(make_command(FUNC_ARM, 0, 0, 0, 0));
      send_command(make_command(FUNC_MIX, 0, 0, 0, 0));
      send_command(make_command(FUNC_MIX, 8191, 8191, -8192, 8191));
      send_command(make_command(FUNC_MIX, 4096, -8192, 8191, -8192));
      send_command(make_command(FUNC_MIX, 2048, 4096, -4096, 0));
      send_command(make_command(FUNC_MIX, 2048, 4096, -4096, 0));
      send_command(make_command(FUNC_MIX, 300, -4096, -4096, -4096));
      send_command(make_command(FUNC_MIX, 1, 1, -1, 0));
      send_command(make_command(FUNC_MIX, 4095, -1, 0, 1));
      send_command(make_command(FUNC_MIX, 206, 4097, -4097, 4097));
      send_command(make_command(FUNC_OFF, 8191, 0, 0, 0));
      send_command(make_command(FUNC_OFF, 0, 0, 0, 0));
      send_command(make_command(FUNC_MIX, 3000, 500, 500, 500));
      send_command(make_command(FUNC_ARM, 8191, -8192, -8192, -8192));
      send_command(make_command(FUNC_MIX, 8191, 0, 0, 0));

      apply_setting(0, 4096, 205, 1000, 2000, 1000, 2500);
      run_random(PHASE_ITEMS / 2, 1'b0);
      wait_results_drained();
      hold_results = 1'b1;
      send_command(make_command(FUNC_ARM, 0, 0, 0, 0));
      repeat (5) send_command(make_command(FUNC_MIX, $urandom_range(0, 4096), random_axis(),
                                           random_axis(), random_axis()));
      wait_results_drained();
      run_random(PHASE_ITEMS / 2, 1'b0);

      apply_setting(4096, 4096, 4096, 20000, 20000, 20000, 20000);
      run_random(PHASE_ITEMS, 1'b0);
      apply_setting(0, 1, 0, 0, 0, 0, 1);
      run_random(PHASE_ITEMS, 1'b1);
      // Bounds out of order, inverted pulse range and a zero period.
      apply_setting(3000, 1000, 2000, 2000, 1000, 0, 0);
      run_random(PHASE_ITEMS, 1'b0);
      // Pulses longer than the period saturate the duty.
      apply_setting(100, 2048, 4096, 500, 20000, 1500, 1500);
      run_random(PHASE_ITEMS, 1'b0);
      apply_setting($urandom_range(0, 600), $urandom_range(2048, 4096),
                    $urandom_range(0, 800), $urandom_range(800, 1200),
                    $urandom_range(1800, 2200), $urandom_range(800, 1200),
                    $urandom_range(2000, 20000));
      run_random(PHASE_ITEMS, 1'b0);
      repeat (2) begin
         apply_setting($urandom_range(0, 4096), $urandom_range(1, 4096),
                       $urandom_range(0, 4096), $urandom_range(0, 20000),
                       $urandom_range(0, 20000), $urandom_range(0, 20000),
                       $urandom_range(1, 20000));
         run_random(PHASE_ITEMS, 1'b0);
      end

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.pending_duties.size() != 0)
         board.report_mismatch("results never returned, count",
                               board.pending_duties.size(), 0);
      $display("Ran %0d commands over %0d register settings: %0d armed mixes (%0d desaturated),",
               sent_count, settings_applied, board.armed_mixes, board.desat_mixes);
      $display("%0d off, %0d arm and %0d ignored commands; %0d results checked, %0d mismatches.",
               board.offs, board.arms, board.ignored, board.results_seen, board.mismatches);
      if (board.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/qxm_pkg.sv
design/qxm_if.sv
design/qxm_serial_div.sv
design/quad_x_mixer_pwm_duty.sv
dv/quad_x_mixer_pwm_duty_test.sv
